// File: rtl/core/priority_interrupt_controller_defines.svh
// Assertion macros for the priority interrupt controller checker.
// Depends on signals clk and rst_n in the scope where a macro is used.
`ifndef PRIORITY_INTERRUPT_CONTROLLER_DEFINES_SVH
`define PRIORITY_INTERRUPT_CONTROLLER_DEFINES_SVH

// Check an implication within the same cycle, outside reset.
`define PIC_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Check an implication in the cycle after the trigger, outside reset.
`define PIC_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// File: rtl/core/pic_pkg.sv
// Shared types, opcodes and sizes for the priority interrupt controller.
// No dependencies.
`default_nettype none

package pic_pkg;

    localparam int NUM_SOURCES = 8;
    localparam int SRC_W       = $clog2(NUM_SOURCES);
    localparam int OP_W        = 4;
    localparam int NEST_W      = 8;
    localparam logic [NEST_W-1:0] NEST_MAX = 8'd255;

    localparam logic [OP_W-1:0] OP_RAISE    = 4'd0;
    localparam logic [OP_W-1:0] OP_MASK_SET = 4'd1;
    localparam logic [OP_W-1:0] OP_MASK_CLR = 4'd2;
    localparam logic [OP_W-1:0] OP_ACK      = 4'd3;
    localparam logic [OP_W-1:0] OP_READ     = 4'd4;
    localparam logic [OP_W-1:0] OP_MOVE     = 4'd5;
    localparam logic [OP_W-1:0] OP_DISPATCH = 4'd6;
    localparam logic [OP_W-1:0] OP_DISABLE  = 4'd7;
    localparam logic [OP_W-1:0] OP_ENABLE   = 4'd8;

    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic [NUM_SOURCES-1:0] raise_bits;
        logic [SRC_W-1:0]       source;
        logic [SRC_W-1:0]       new_rank;
    } request_t;

    typedef struct packed {
        logic [NUM_SOURCES-1:0] status_bits;
        logic [NUM_SOURCES-1:0] mask_bits;
        logic                   irq_line;
        logic                   serviced_valid;
        logic [SRC_W-1:0]       serviced_source;
        logic                   op_ok;
        logic                   global_enable;
        logic                   last;
    } result_t;

    // Controller to rank chain
    typedef struct packed {
        logic             rotate;
        logic             move;
        logic [SRC_W-1:0] src;
        logic [SRC_W-1:0] nr;
    } chain_req_t;

    // Rank chain to controller
    typedef struct packed {
        logic [SRC_W-1:0] head;
        logic             found;
    } chain_stat_t;

    // Rank chain to each cell
    typedef struct packed {
        logic             rotate;
        logic             move;
        logic [SRC_W-1:0] src;
        logic [SRC_W-1:0] cur;
        logic [SRC_W-1:0] nr;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/pic_rank_cell.sv
// One slot of the rank table: holds a source index and shifts with its neighbors.
// Depends on pic_pkg.
`default_nettype none

module pic_rank_cell (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire [pic_pkg::SRC_W-1:0] cell_idx,
    input  pic_pkg::cell_ctrl_t      ctrl,
    input  wire [pic_pkg::SRC_W-1:0] from_prev,
    input  wire [pic_pkg::SRC_W-1:0] from_next,
    output logic [pic_pkg::SRC_W-1:0] entry
);
    import pic_pkg::*;

    logic [SRC_W-1:0] entry_reg;
    logic [SRC_W-1:0] entry_next;

    // Rotate toward slot zero, or take part in a rank move
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.rotate)
        begin
            entry_next = from_next;
        end
        else if (ctrl.move)
        begin
            if (cell_idx == ctrl.nr)
            begin
                entry_next = ctrl.src;
            end
            else if ((ctrl.cur > ctrl.nr) && (cell_idx > ctrl.nr) && (cell_idx <= ctrl.cur))
            begin
                entry_next = from_prev;
            end
            else if ((ctrl.cur < ctrl.nr) && (cell_idx >= ctrl.cur) && (cell_idx < ctrl.nr))
            begin
                entry_next = from_next;
            end
        end
    end

    // Hold the slot; reset to identity order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= cell_idx;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// File: rtl/core/pic_rank_chain.sv
// Row of rank cells forming the reorderable priority table, with source lookup.
// Depends on pic_pkg and pic_rank_cell.
`default_nettype none

module pic_rank_chain (
    input  wire                  clk,
    input  wire                  rst_n,
    input  pic_pkg::chain_req_t  req,
    output pic_pkg::chain_stat_t stat
);
    import pic_pkg::*;

    logic [SRC_W-1:0] entries [NUM_SOURCES];
    logic             found;
    logic [SRC_W-1:0] cur;
    cell_ctrl_t       cell_ctrl;

    // Locate the slot that holds the requested source
    always_comb
    begin
        found = 1'b0;
        cur   = '0;
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            if (entries[i] == req.src)
            begin
                found = 1'b1;
                cur   = SRC_W'(i);
            end
        end
    end

    // Drop a move whose source is absent
    always_comb
    begin
        cell_ctrl.rotate = req.rotate;
        cell_ctrl.move   = req.move && found;
        cell_ctrl.src    = req.src;
        cell_ctrl.cur    = cur;
        cell_ctrl.nr     = req.nr;
    end

    for (genvar g = 0; g < NUM_SOURCES; g++)
    begin : g_cell
        pic_rank_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_idx  (SRC_W'(g)),
            .ctrl      (cell_ctrl),
            .from_prev (entries[(g + NUM_SOURCES - 1) % NUM_SOURCES]),
            .from_next (entries[(g + 1) % NUM_SOURCES]),
            .entry     (entries[g])
        );
    end

    assign stat.head  = entries[0];
    assign stat.found = found;

endmodule

`default_nettype wire

// File: rtl/core/priority_interrupt_controller.sv
// Priority interrupt controller top level: status, mask, nesting and dispatch control.
// Depends on pic_pkg and pic_rank_chain.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. It
//   carries op, raise_bits, source and new_rank. Results appear on result,
//   each for one cycle while strobe is high; the receiver cannot stall, so
//   every strobed result must be captured in that cycle.
//   Every request other than a dispatch gives one result, strobed in the
//   cycle after acceptance, and busy stays low: one request per cycle.
//   A dispatch with nothing pending also gives one result the next cycle.
//   A dispatch with pending sources raises busy while the rank chain
//   rotates through all NUM_SOURCES slots, once per cycle, and each pending
//   source at the chain head gives one result the next cycle, in rank order.
//   The last result of a request has last set. The chain is back in its
//   original order when busy falls.
//   Reset clears status, mask and global enable, sets the disable nesting
//   count to one and loads the rank table in identity order.
`default_nettype none

module priority_interrupt_controller (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    output logic               busy,
    input  pic_pkg::request_t  request,
    output logic               strobe,
    output pic_pkg::result_t   result
);
    import pic_pkg::*;

    localparam int CNT_W = $clog2(NUM_SOURCES);

    logic [NUM_SOURCES-1:0] pending_reg, pending_next;
    logic [NUM_SOURCES-1:0] mask_reg, mask_next;
    logic [NEST_W-1:0]      nest_reg, nest_next;
    logic                   global_reg, global_next;
    logic                   busy_reg, busy_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   strobe_reg, strobe_next;
    result_t                result_reg, result_next;

    logic                   accept;
    logic                   rank_ok;
    logic                   move_ok;
    logic [NUM_SOURCES-1:0] head_bit;
    logic [NEST_W-1:0]      nest_dec;
    chain_req_t             chain_req;
    chain_stat_t            chain_stat;

    assign accept   = start && !busy_reg;
    assign rank_ok  = int'(request.new_rank) < NUM_SOURCES;
    assign move_ok  = rank_ok && chain_stat.found;
    assign head_bit = NUM_SOURCES'(1) << chain_stat.head;
    assign nest_dec = nest_reg - NEST_W'(1);

    // Drive the rank chain: rotate while dispatching, move on request
    always_comb
    begin
        chain_req.rotate = busy_reg;
        chain_req.move   = accept && (request.op == OP_MOVE) && rank_ok;
        chain_req.src    = request.source;
        chain_req.nr     = request.new_rank;
    end

    pic_rank_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (chain_req),
        .stat  (chain_stat)
    );

    // Apply the request, or advance the dispatch walk
    always_comb
    begin
        pending_next = pending_reg;
        mask_next    = mask_reg;
        nest_next    = nest_reg;
        global_next  = global_reg;
        busy_next    = busy_reg;
        cnt_next     = cnt_reg;
        strobe_next  = 1'b0;
        result_next  = result_reg;

        if (busy_reg)
        begin
            // Serve the source at the chain head if it is pending
            pending_next = pending_reg & ~head_bit;
            cnt_next     = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NUM_SOURCES - 1))
            begin
                busy_next = 1'b0;
            end
            strobe_next                 = |(pending_reg & head_bit);
            result_next.status_bits     = '0;
            result_next.mask_bits       = mask_reg;
            result_next.irq_line        = 1'b0;
            result_next.serviced_valid  = 1'b1;
            result_next.serviced_source = chain_stat.head;
            result_next.op_ok           = 1'b1;
            result_next.global_enable   = global_reg;
            result_next.last            = (pending_next == '0);
        end
        else if (accept)
        begin
            case (request.op)
                OP_RAISE:    pending_next = pending_reg | request.raise_bits;
                OP_MASK_SET: mask_next[request.source] = 1'b1;
                OP_MASK_CLR: mask_next[request.source] = 1'b0;
                OP_ACK:      pending_next[request.source] = 1'b0;
                OP_DISPATCH:
                begin
                    if (pending_reg != '0)
                    begin
                        busy_next = 1'b1;
                        cnt_next  = '0;
                    end
                end
                OP_DISABLE:
                begin
                    if (nest_reg != NEST_MAX)
                    begin
                        nest_next = nest_reg + NEST_W'(1);
                    end
                    global_next = 1'b0;
                end
                OP_ENABLE:
                begin
                    if (nest_reg != '0)
                    begin
                        nest_next = nest_dec;
                        if (nest_dec == '0)
                        begin
                            global_next = 1'b1;
                        end
                    end
                    else
                    begin
                        global_next = 1'b1;
                    end
                end
                default: ;
            endcase

            // One result unless a dispatch walk starts
            strobe_next                 = !busy_next;
            result_next.status_bits     = pending_next;
            result_next.mask_bits       = mask_next;
            result_next.irq_line        = global_next && |(pending_next & mask_next);
            result_next.serviced_valid  = 1'b0;
            result_next.serviced_source = '0;
            result_next.op_ok           = (request.op != OP_MOVE) || move_ok;
            result_next.global_enable   = global_next;
            result_next.last            = 1'b1;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            mask_reg    <= '0;
            nest_reg    <= NEST_W'(1);
            global_reg  <= 1'b0;
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            mask_reg    <= mask_next;
            nest_reg    <= nest_next;
            global_reg  <= global_next;
            busy_reg    <= busy_next;
            cnt_reg     <= cnt_next;
            strobe_reg  <= strobe_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = busy_reg;
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// File: rtl/core/pic_checker.sv
// Port-level checks for the priority interrupt controller, bound to the top level.
// Depends on pic_pkg and priority_interrupt_controller_defines.svh.
`default_nettype none
`include "priority_interrupt_controller_defines.svh"

module pic_checker (
    input wire               clk,
    input wire               rst_n,
    input wire               start,
    input wire               busy,
    input pic_pkg::request_t request,
    input wire               strobe,
    input pic_pkg::result_t  result
);
    import pic_pkg::*;

    logic acc;
    assign acc = start && !busy;

    `PIC_ASSERT_NEXT(a_single_result, acc && (request.op != OP_DISPATCH), strobe && result.last && !busy, "non-dispatch request must give one final result next cycle")
    `PIC_ASSERT_NEXT(a_dispatch_reacts, acc && (request.op == OP_DISPATCH), strobe || busy, "dispatch must give a result or start its walk")
    `PIC_ASSERT_NOW(a_plain_is_last, strobe && !result.serviced_valid, result.last, "result without serviced source must be final")
    `PIC_ASSERT_NOW(a_dispatch_clears, strobe && result.serviced_valid, (result.status_bits == '0) && !result.irq_line, "dispatch result must show all sources cleared")
    `PIC_ASSERT_NOW(a_irq_gated, strobe && result.irq_line, result.global_enable, "irq line without global enable")

endmodule

bind priority_interrupt_controller pic_checker u_pic_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .strobe  (strobe),
    .result  (result)
);

`default_nettype wire
